// File: sv/src_pkg.sv
package src_pkg;

    localparam int CoordW = 32;
    localparam int MagW   = CoordW + 1;
    localparam int ProdW  = 2 * MagW;
    localparam int NumCut = 4;
    localparam int DivLat = MagW + 1;

    // configuration register indexes
    localparam logic [1:0] REG_LEFT   = 2'd0;
    localparam logic [1:0] REG_RIGHT  = 2'd1;
    localparam logic [1:0] REG_BOTTOM = 2'd2;
    localparam logic [1:0] REG_TOP    = 2'd3;

    typedef logic signed [CoordW-1:0] coord_t;
    typedef logic [MagW-1:0]          mag_t;

    // per-word info that rides alongside the divider lanes
    typedef struct packed {
        coord_t           x0;
        coord_t           y0;
        coord_t           x1;
        coord_t           y1;
        logic             in0;
        logic             in1;
        logic             zero_len;
        logic             dx_pos;
        logic             dx_neg;
        logic             dy_pos;
        logic             dy_neg;
        logic [NumCut-1:0] try_cut;
        logic [NumCut-1:0] neg;
    } side_t;

    function automatic mag_t mag33(input logic signed [MagW-1:0] v);
        mag_t r;
        r = v[MagW-1] ? mag_t'(-v) : mag_t'(v);
        return r;
    endfunction

endpackage

// File: sv/segment_rectangle_clipper_core.sv
// Clips one segment (signed Q16.16 start and end points) per word against the
// rectangle held in four configuration registers and returns the visible part
// in the segment's own direction plus a visible flag; hidden results carry
// zero coordinates. The block is a fixed 37-stage pipeline: one input
// register, four parallel lanes each with a 33x33 magnitude multiply stage and
// a 33-stage restoring divider (one quotient bit per stage), then a cut/range
// stage and the output register. A new word is taken every cycle unless the
// output word is stalled, so the sustained rate is one segment per clock while
// the output flows. The whole pipeline advances together and holds
// while the output word is stalled. Configuration writes (cfg_ready is always
// high) must only be issued with no segment in flight. Reset gives the
// rectangle [0, 0x7FFFFFFF] in both axes.
module segment_rectangle_clipper_core (
    input  logic                    clk,
    input  logic                    rst_n,
    // segment input
    input  logic                    in_valid,
    output logic                    in_stall,
    input  src_pkg::coord_t         start_x,
    input  src_pkg::coord_t         start_y,
    input  src_pkg::coord_t         end_x,
    input  src_pkg::coord_t         end_y,
    // clipped result
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic                    visible,
    output src_pkg::coord_t         clip_start_x,
    output src_pkg::coord_t         clip_start_y,
    output src_pkg::coord_t         clip_end_x,
    output src_pkg::coord_t         clip_end_y,
    // register writes
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [1:0]              cfg_index,
    input  logic [31:0]             cfg_data
);

    localparam int Lat = src_pkg::DivLat;

    // rectangle registers
    src_pkg::coord_t left_edge_reg, right_edge_reg, bottom_edge_reg, top_edge_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_edge_reg   <= 32'sh0000_0000;
            right_edge_reg  <= 32'sh7FFF_FFFF;
            bottom_edge_reg <= 32'sh0000_0000;
            top_edge_reg    <= 32'sh7FFF_FFFF;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                src_pkg::REG_LEFT:   left_edge_reg   <= cfg_data;
                src_pkg::REG_RIGHT:  right_edge_reg  <= cfg_data;
                src_pkg::REG_BOTTOM: bottom_edge_reg <= cfg_data;
                src_pkg::REG_TOP:    top_edge_reg    <= cfg_data;
                default:             left_edge_reg   <= left_edge_reg;
            endcase
        end
    end

    // global advance: everything moves unless the output word is held
    logic en;
    assign en       = !out_valid || !out_stall;
    assign in_stall = !en;

    // front: deltas, inside tests, per-edge operand magnitudes
    logic            f_valid;
    src_pkg::side_t  f_side;
    src_pkg::mag_t   f_mag_d   [src_pkg::NumCut];
    src_pkg::mag_t   f_mag_t   [src_pkg::NumCut];
    src_pkg::mag_t   f_mag_den [src_pkg::NumCut];

    src_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (in_valid),
        .start_x     (start_x),
        .start_y     (start_y),
        .end_x       (end_x),
        .end_y       (end_y),
        .left_edge   (left_edge_reg),
        .right_edge  (right_edge_reg),
        .bottom_edge (bottom_edge_reg),
        .top_edge    (top_edge_reg),
        .valid_reg   (f_valid),
        .side_reg    (f_side),
        .mag_d_reg   (f_mag_d),
        .mag_t_reg   (f_mag_t),
        .mag_den_reg (f_mag_den)
    );

    // one multiply/divide lane per rectangle edge
    src_pkg::mag_t quot [src_pkg::NumCut];

    for (genvar k = 0; k < src_pkg::NumCut; k++)
    begin : g_lane
        src_muldiv u_muldiv (
            .clk  (clk),
            .en   (en),
            .a    (f_mag_d[k]),
            .b    (f_mag_t[k]),
            .den  (f_mag_den[k]),
            .quot (quot[k])
        );
    end

    // side info and valid bits travel alongside the lanes
    logic           valid_pipe_reg [Lat];
    src_pkg::side_t side_pipe_reg  [Lat];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < Lat; i++)
            begin
                valid_pipe_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            valid_pipe_reg[0] <= f_valid;
            for (int i = 1; i < Lat; i++)
            begin
                valid_pipe_reg[i] <= valid_pipe_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_pipe_reg[0] <= f_side;
            for (int i = 1; i < Lat; i++)
            begin
                side_pipe_reg[i] <= side_pipe_reg[i-1];
            end
        end
    end

    // back end: cut coordinates, selection, output register
    src_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .in_valid      (valid_pipe_reg[Lat-1]),
        .side          (side_pipe_reg[Lat-1]),
        .quot          (quot),
        .left_edge     (left_edge_reg),
        .right_edge    (right_edge_reg),
        .bottom_edge   (bottom_edge_reg),
        .top_edge      (top_edge_reg),
        .out_valid_reg (out_valid),
        .visible_reg   (visible),
        .sx_reg        (clip_start_x),
        .sy_reg        (clip_start_y),
        .ex_reg        (clip_end_x),
        .ey_reg        (clip_end_y)
    );

    // hidden results carry zero coordinates
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !visible |-> clip_start_x == '0 && clip_start_y == '0 &&
                                  clip_end_x == '0 && clip_end_y == '0)
        else $error("hidden result with nonzero coordinates");

    // a held output freezes the lane valid bits
    assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(valid_pipe_reg[Lat-1]) && $stable(f_valid))
        else $error("pipeline moved while output held");

    // an accepted word enters the front register
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> f_valid)
        else $error("accepted word lost at pipeline entry");

endmodule

// File: sv/src_front.sv
module src_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  src_pkg::coord_t       start_x,
    input  src_pkg::coord_t       start_y,
    input  src_pkg::coord_t       end_x,
    input  src_pkg::coord_t       end_y,
    input  src_pkg::coord_t       left_edge,
    input  src_pkg::coord_t       right_edge,
    input  src_pkg::coord_t       bottom_edge,
    input  src_pkg::coord_t       top_edge,
    output logic                  valid_reg,
    output src_pkg::side_t        side_reg,
    output src_pkg::mag_t         mag_d_reg   [src_pkg::NumCut],
    output src_pkg::mag_t         mag_t_reg   [src_pkg::NumCut],
    output src_pkg::mag_t         mag_den_reg [src_pkg::NumCut]
);

    logic signed [src_pkg::MagW-1:0] dx, dy;
    logic signed [src_pkg::MagW-1:0] t_val [src_pkg::NumCut];
    logic signed [src_pkg::MagW-1:0] d_val [src_pkg::NumCut];
    logic signed [src_pkg::MagW-1:0] n_val [src_pkg::NumCut];
    src_pkg::coord_t edge_val [src_pkg::NumCut];
    src_pkg::side_t  side_next;

    always_comb
    begin
        dx = {end_x[31], end_x} - {start_x[31], start_x};
        dy = {end_y[31], end_y} - {start_y[31], start_y};
        edge_val[0] = left_edge;
        edge_val[1] = bottom_edge;
        edge_val[2] = right_edge;
        edge_val[3] = top_edge;

        side_next.x0       = start_x;
        side_next.y0       = start_y;
        side_next.x1       = end_x;
        side_next.y1       = end_y;
        side_next.in0      = (start_x >= left_edge) && (start_x <= right_edge) &&
                             (start_y >= bottom_edge) && (start_y <= top_edge);
        side_next.in1      = (end_x >= left_edge) && (end_x <= right_edge) &&
                             (end_y >= bottom_edge) && (end_y <= top_edge);
        side_next.zero_len = (dx == '0) && (dy == '0);
        side_next.dx_pos   = !dx[32] && (dx != '0);
        side_next.dx_neg   = dx[32];
        side_next.dy_pos   = !dy[32] && (dy != '0);
        side_next.dy_neg   = dy[32];

        for (int k = 0; k < src_pkg::NumCut; k++)
        begin
            if ((k % 2) == 0)
            begin
                // vertical edge: solve for y
                t_val[k] = {edge_val[k][31], edge_val[k]} - {start_x[31], start_x};
                d_val[k] = dy;
                n_val[k] = dx;
                side_next.try_cut[k] = (dx != '0) &&
                    (((start_x <= edge_val[k]) && (edge_val[k] <= end_x)) ||
                     ((end_x <= edge_val[k]) && (edge_val[k] <= start_x)));
            end
            else
            begin
                // horizontal edge: solve for x (dx of zero gives x0 == x1)
                t_val[k] = {edge_val[k][31], edge_val[k]} - {start_y[31], start_y};
                d_val[k] = dx;
                n_val[k] = dy;
                side_next.try_cut[k] = (dy != '0) &&
                    (((start_y <= edge_val[k]) && (edge_val[k] <= end_y)) ||
                     ((end_y <= edge_val[k]) && (edge_val[k] <= start_y)));
            end
            side_next.neg[k] = d_val[k][32] ^ t_val[k][32] ^ n_val[k][32];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg <= side_next;
            for (int k = 0; k < src_pkg::NumCut; k++)
            begin
                mag_d_reg[k]   <= src_pkg::mag33(d_val[k]);
                mag_t_reg[k]   <= src_pkg::mag33(t_val[k]);
                mag_den_reg[k] <= src_pkg::mag33(n_val[k]);
            end
        end
    end

endmodule

// File: sv/src_muldiv.sv
module src_muldiv (
    input  logic          clk,
    input  logic          en,
    input  src_pkg::mag_t a,
    input  src_pkg::mag_t b,
    input  src_pkg::mag_t den,
    output src_pkg::mag_t quot
);

    localparam int W = src_pkg::MagW;

    logic [src_pkg::ProdW-1:0] prod_reg;
    src_pkg::mag_t             den_p_reg;
    src_pkg::mag_t             rem_reg  [W];
    src_pkg::mag_t             lowq_reg [W];
    src_pkg::mag_t             den_reg  [W];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg  <= a * b;
            den_p_reg <= den;
        end
    end

    // one quotient bit per stage; low dividend bits shift out as quotient bits shift in
    for (genvar i = 0; i < W; i++)
    begin : g_div
        src_pkg::mag_t rem_in, lowq_in, den_in, rem_next;
        logic [W:0]    trial;
        logic          ge;

        if (i == 0)
        begin : g_first
            assign rem_in  = prod_reg[src_pkg::ProdW-1:W];
            assign lowq_in = prod_reg[W-1:0];
            assign den_in  = den_p_reg;
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[i-1];
            assign lowq_in = lowq_reg[i-1];
            assign den_in  = den_reg[i-1];
        end

        always_comb
        begin
            trial    = {rem_in, lowq_in[W-1]};
            ge       = trial >= {1'b0, den_in};
            rem_next = ge ? W'(trial - {1'b0, den_in}) : trial[W-1:0];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= rem_next;
                lowq_reg[i] <= {lowq_in[W-2:0], ge};
                den_reg[i]  <= den_in;
            end
        end
    end

    assign quot = lowq_reg[W-1];

endmodule

// File: sv/src_back.sv
module src_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  src_pkg::side_t  side,
    input  src_pkg::mag_t   quot [src_pkg::NumCut],
    input  src_pkg::coord_t left_edge,
    input  src_pkg::coord_t right_edge,
    input  src_pkg::coord_t bottom_edge,
    input  src_pkg::coord_t top_edge,
    output logic            out_valid_reg,
    output logic            visible_reg,
    output src_pkg::coord_t sx_reg,
    output src_pkg::coord_t sy_reg,
    output src_pkg::coord_t ex_reg,
    output src_pkg::coord_t ey_reg
);

    localparam int CW = src_pkg::MagW + 2;

    src_pkg::coord_t       edge_val [src_pkg::NumCut];
    logic signed [CW-1:0]  coord    [src_pkg::NumCut];
    logic signed [CW-1:0]  qs       [src_pkg::NumCut];
    logic signed [CW-1:0]  lo_ext, hi_ext;
    logic [src_pkg::NumCut-1:0] keep_next;
    src_pkg::coord_t       cx_next  [src_pkg::NumCut];
    src_pkg::coord_t       cy_next  [src_pkg::NumCut];

    logic                  b1_valid_reg;
    src_pkg::side_t        b1_side_reg;
    logic [src_pkg::NumCut-1:0] keep_reg;
    src_pkg::coord_t       cx_reg   [src_pkg::NumCut];
    src_pkg::coord_t       cy_reg   [src_pkg::NumCut];

    // stage 1: cut coordinates and edge-range tests
    always_comb
    begin
        edge_val[0] = left_edge;
        edge_val[1] = bottom_edge;
        edge_val[2] = right_edge;
        edge_val[3] = top_edge;
        for (int k = 0; k < src_pkg::NumCut; k++)
        begin
            qs[k] = side.neg[k] ? -CW'(quot[k]) : CW'(quot[k]);
            if ((k % 2) == 0)
            begin
                coord[k]     = CW'(side.y0) + qs[k];
                lo_ext       = CW'(bottom_edge);
                hi_ext       = CW'(top_edge);
                keep_next[k] = side.try_cut[k] && (coord[k] >= lo_ext) && (coord[k] < hi_ext);
                cx_next[k]   = edge_val[k];
                cy_next[k]   = coord[k][31:0];
            end
            else
            begin
                coord[k]     = CW'(side.x0) + qs[k];
                lo_ext       = CW'(left_edge);
                hi_ext       = CW'(right_edge);
                keep_next[k] = side.try_cut[k] && (coord[k] > lo_ext) && (coord[k] <= hi_ext);
                cx_next[k]   = coord[k][31:0];
                cy_next[k]   = edge_val[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b1_side_reg <= side;
            keep_reg    <= keep_next;
            cx_reg      <= cx_next;
            cy_reg      <= cy_next;
        end
    end

    // stage 2: pick first two cuts, order them, form the word
    logic [1:0]            hits;
    src_pkg::coord_t       c0x, c0y, c1x, c1y;
    logic signed [src_pkg::MagW-1:0] dsx, dsy;
    logic                  flip;
    logic                  vis_next;
    src_pkg::coord_t       sx_next, sy_next, ex_next, ey_next;

    always_comb
    begin
        hits = 2'd0;
        c0x  = '0;
        c0y  = '0;
        c1x  = '0;
        c1y  = '0;
        for (int k = 0; k < src_pkg::NumCut; k++)
        begin
            if (keep_reg[k])
            begin
                if (hits == 2'd0)
                begin
                    c0x  = cx_reg[k];
                    c0y  = cy_reg[k];
                    hits = 2'd1;
                end
                else if (hits == 2'd1)
                begin
                    c1x  = cx_reg[k];
                    c1y  = cy_reg[k];
                    hits = 2'd2;
                end
            end
        end
        dsx  = {c1x[31], c1x} - {c0x[31], c0x};
        dsy  = {c1y[31], c1y} - {c0y[31], c0y};
        flip = (dsx[32] && b1_side_reg.dx_pos) ||
               (!dsx[32] && (dsx != '0) && b1_side_reg.dx_neg) ||
               (dsy[32] && b1_side_reg.dy_pos) ||
               (!dsy[32] && (dsy != '0) && b1_side_reg.dy_neg);

        vis_next = 1'b0;
        sx_next  = '0;
        sy_next  = '0;
        ex_next  = '0;
        ey_next  = '0;
        if (b1_side_reg.in0 && b1_side_reg.in1)
        begin
            vis_next = !b1_side_reg.zero_len;
            sx_next  = b1_side_reg.x0;
            sy_next  = b1_side_reg.y0;
            ex_next  = b1_side_reg.x1;
            ey_next  = b1_side_reg.y1;
        end
        else if (!b1_side_reg.zero_len)
        begin
            if (hits == 2'd2)
            begin
                vis_next = 1'b1;
                sx_next  = flip ? c1x : c0x;
                sy_next  = flip ? c1y : c0y;
                ex_next  = flip ? c0x : c1x;
                ey_next  = flip ? c0y : c1y;
            end
            else if (hits == 2'd1 && b1_side_reg.in0)
            begin
                vis_next = 1'b1;
                sx_next  = b1_side_reg.x0;
                sy_next  = b1_side_reg.y0;
                ex_next  = c0x;
                ey_next  = c0y;
            end
            else if (hits == 2'd1 && b1_side_reg.in1)
            begin
                vis_next = 1'b1;
                sx_next  = c0x;
                sy_next  = c0y;
                ex_next  = b1_side_reg.x1;
                ey_next  = b1_side_reg.y1;
            end
        end
        if (!vis_next)
        begin
            sx_next = '0;
            sy_next = '0;
            ex_next = '0;
            ey_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            b1_valid_reg  <= in_valid;
            out_valid_reg <= b1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            visible_reg <= vis_next;
            sx_reg      <= sx_next;
            sy_reg      <= sy_next;
            ex_reg      <= ex_next;
            ey_reg      <= ey_next;
        end
    end

endmodule
